/* hw/rtl/hcrf_pkg.sv */
// hcrf_pkg: shared constants and the quarter-wave sine table for the
// heading compensated range filter; no dependencies
package hcrf_pkg;

  localparam int DefWindowDepth = 8;
  localparam int FullTurn       = 36000;
  localparam int QuarterTurn    = 9000;
  localparam logic [9:0] TolReset = 10'd500;
  localparam logic [16:0] CompMax = 17'h1FFFF;

  // round(32768*sin(k deg)), k = 0..90
  function automatic logic [15:0] sine_lut(input logic [6:0] k);
    logic [15:0] v;
    unique case (k)
      7'd0: v = 16'd0;     7'd1: v = 16'd572;   7'd2: v = 16'd1144;  7'd3: v = 16'd1715;
      7'd4: v = 16'd2286;  7'd5: v = 16'd2856;  7'd6: v = 16'd3425;  7'd7: v = 16'd3993;
      7'd8: v = 16'd4560;  7'd9: v = 16'd5126;  7'd10: v = 16'd5690; 7'd11: v = 16'd6252;
      7'd12: v = 16'd6813; 7'd13: v = 16'd7371; 7'd14: v = 16'd7927; 7'd15: v = 16'd8481;
      7'd16: v = 16'd9032; 7'd17: v = 16'd9580; 7'd18: v = 16'd10126; 7'd19: v = 16'd10668;
      7'd20: v = 16'd11207; 7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365; 7'd27: v = 16'd14876;
      7'd28: v = 16'd15384; 7'd29: v = 16'd15886; 7'd30: v = 16'd16384; 7'd31: v = 16'd16877;
      7'd32: v = 16'd17364; 7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174; 7'd39: v = 16'd20622;
      7'd40: v = 16'd21063; 7'd41: v = 16'd21498; 7'd42: v = 16'd21926; 7'd43: v = 16'd22348;
      7'd44: v = 16'd22763; 7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102; 7'd51: v = 16'd25466;
      7'd52: v = 16'd25822; 7'd53: v = 16'd26170; 7'd54: v = 16'd26510; 7'd55: v = 16'd26842;
      7'd56: v = 16'd27166; 7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932; 7'd63: v = 16'd29197;
      7'd64: v = 16'd29452; 7'd65: v = 16'd29698; 7'd66: v = 16'd29935; 7'd67: v = 16'd30163;
      7'd68: v = 16'd30382; 7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499; 7'd75: v = 16'd31651;
      7'd76: v = 16'd31795; 7'd77: v = 16'd31928; 7'd78: v = 16'd32052; 7'd79: v = 16'd32166;
      7'd80: v = 16'd32270; 7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688; 7'd87: v = 16'd32723;
      7'd88: v = 16'd32748; 7'd89: v = 16'd32763; 7'd90: v = 16'd32768;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/heading_compensated_range_filter_unit.sv */
// heading_compensated_range_filter_unit: moving averages, relative yaw and
// rotation compensation of four range readings; uses hcrf_pkg
//
//  channel | ports                              | handshake
//  in      | in_*_distance, in_raw_heading       | in_valid / in_ready
//  out     | out_avg_*, out_relative_yaw, out_comp_* | out_valid / out_ready
//  cfg     | cfg_snap_tolerance                  | cfg_we, no wait
//
// one item at a time: the next item is accepted only after the result is taken; the
// multiplier steps are skipped when the yaw falls in a snap band
// a window sweep of WINDOW_DEPTH entries with one adder per lane, a reciprocal
// divide by the depth, then short steps through one 17x16 multiplier and one
// 38 bit adder; out_valid rises once the compensated values are registered
// the windows are flip-flop rows cleared at reset; reset also clears the
// reference and sets the tolerance to 500
// in_ready is high only in idle; the result register holds until taken
module heading_compensated_range_filter_unit
  import hcrf_pkg::*;
#(
  parameter int WINDOW_DEPTH = hcrf_pkg::DefWindowDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_north_distance,
  input  logic [15:0] in_east_distance,
  input  logic [15:0] in_south_distance,
  input  logic [15:0] in_west_distance,
  input  logic [15:0] in_raw_heading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_avg_north,
  output logic [15:0] out_avg_east,
  output logic [15:0] out_avg_south,
  output logic [15:0] out_avg_west,
  output logic [15:0] out_relative_yaw,
  output logic [16:0] out_comp_north,
  output logic [16:0] out_comp_east,
  output logic [16:0] out_comp_south,
  output logic [16:0] out_comp_west,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_snap_tolerance
);
  localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int AW = 16 + SW;
  // reciprocal of the depth, exact floor for any window sum
  localparam int RK = AW + SW;
  localparam longint RM = ((longint'(1) << RK) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_YAW, S_SIN0, S_SIN1, S_SIN2, S_SIN3, S_SIN4, S_SIN5,
    S_SNAP, S_MUL0, S_MUL1, S_MUL2, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] win_r [5][WINDOW_DEPTH];
  logic [SW-1:0] slot_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] acc_r [5];
  logic [15:0] avg_r [5];
  logic ref_taken_r;
  logic [15:0] ref_r;
  logic [9:0] tol_r;
  logic [15:0] yaw_r;
  logic [1:0] quad_r;
  logic [13:0] rem_r;       // remainder within the quadrant
  logic [15:0] sa_r, sb_r;  // sine of rem and of quarter minus rem
  logic [15:0] lo_r, hi_r;
  logic [6:0] frac_r;
  logic [1:0] dir_r;        // which direction the multiplier serves
  logic       term_r;       // 0: own*cos, 1: neighbour*sin
  logic       which_r;      // 0: building sa, 1: building sb
  logic signed [37:0] sum_r;
  logic [16:0] comp_r [4];

  // shared multiplier: 17 bit signed by 16 bit unsigned
  logic signed [16:0] mul_a;
  logic [15:0] mul_b;
  logic signed [33:0] mul_p;
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // sine and cosine with signs, from quadrant
  logic signed [16:0] sn, cs;
  always_comb begin
    unique case (quad_r)
      2'd0: begin sn = {1'b0, sa_r}; cs = {1'b0, sb_r}; end
      2'd1: begin sn = {1'b0, sb_r}; cs = -$signed({1'b0, sa_r}); end
      2'd2: begin sn = -$signed({1'b0, sa_r}); cs = -$signed({1'b0, sb_r}); end
      default: begin sn = -$signed({1'b0, sb_r}); cs = {1'b0, sa_r}; end
    endcase
  end

  // neighbour of N is W, of E is N, of S is E, of W is S
  logic [1:0] nb_idx;
  assign nb_idx = dir_r - 2'd1;
  always_comb begin
    mul_a = term_r ? sn : cs;
    mul_b = term_r ? avg_r[nb_idx] : avg_r[dir_r];
    if (state_r == S_SIN2) begin
      mul_a = $signed({1'b0, hi_r - lo_r});
      mul_b = {9'd0, frac_r};
    end
  end

  // yaw difference wrapped into a full turn; out of range headings can
  // push the difference past one turn either way
  logic signed [17:0] dif;
  logic [17:0] yw;
  always_comb begin
    dif = $signed({2'b00, avg_r[4]}) - $signed({2'b00, ref_taken_r ? ref_r : avg_r[4]});
    if (dif < -18'sd36000) yw = 18'(dif + 18'sd72000);
    else if (dif < 18'sd0) yw = 18'(dif + 18'sd36000);
    else if (dif >= 18'sd36000) yw = 18'(dif - 18'sd36000);
    else yw = 18'(dif);
  end

  // snap band tests
  logic [16:0] y17, t17;
  logic b90, b180, b270;
  assign y17 = {1'b0, yaw_r};
  assign t17 = {7'd0, tol_r};
  assign b90  = (y17 + t17 >= 17'd9000)  && (y17 <= 17'd9000 + t17);
  assign b180 = (y17 + t17 >= 17'd18000) && (y17 <= 17'd18000 + t17);
  assign b270 = (y17 + t17 >= 17'd27000) && (y17 <= 17'd27000 + t17);

  // magnitude round and saturate
  logic [37:0] mag;
  logic [22:0] rnd;
  always_comb begin
    mag = sum_r[37] ? 38'(-sum_r) : 38'(sum_r);
    rnd = 23'(((mag + 38'd16384) >> 15) + 38'd1);
  end

  // interpolation divide by 100 of (d*f + 50), d*f < 2^16
  logic [16:0] ip_num;
  logic [33:0] ip_q;
  assign ip_num = 17'(sum_r[16:0]) + 17'd50;
  assign ip_q = 34'(ip_num) * 34'd41944;   // floor(n/100) for n < 2^17 after correction

  logic [15:0] ip_div;
  always_comb begin
    ip_div = 16'(ip_q >> 22);
    if (17'(ip_num) >= 17'(ip_div) * 17'd100 + 17'd100) ip_div = ip_div + 16'd1;
    else if (17'(ip_div) * 17'd100 > ip_num) ip_div = ip_div - 16'd1;
  end

  logic [15:0] sin_val;
  assign sin_val = lo_r + ip_div;

  logic [13:0] arg;
  assign arg = which_r ? 14'(14'd9000 - rem_r) : rem_r;

  // whole degrees and hundredths of arg, reciprocal exact for arg <= 9000
  logic [26:0] deg_p;
  logic [6:0] deg;
  logic [13:0] deg_frac;
  assign deg_p = 27'(arg) * 27'd5243;
  assign deg = 7'(deg_p >> 19);
  assign deg_frac = arg - 14'(deg) * 14'd100;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int c = 0; c < 5; c++)
        for (int i = 0; i < WINDOW_DEPTH; i++) win_r[c][i] <= '0;
      slot_r <= '0;
      ref_taken_r <= 1'b0;
      ref_r <= '0;
      tol_r <= TolReset;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) tol_r <= cfg_snap_tolerance;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            win_r[0][slot_r] <= in_north_distance;
            win_r[1][slot_r] <= in_east_distance;
            win_r[2][slot_r] <= in_south_distance;
            win_r[3][slot_r] <= in_west_distance;
            win_r[4][slot_r] <= in_raw_heading;
            slot_r <= (32'(slot_r) == WINDOW_DEPTH - 1) ? '0 : slot_r + 1'b1;
            for (int c = 0; c < 5; c++) acc_r[c] <= '0;
            cnt_r <= '0;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          // one window entry per lane each cycle
          for (int c = 0; c < 5; c++)
            acc_r[c] <= acc_r[c] + AW'(win_r[c][cnt_r[SW-1:0]]);
          if (32'(cnt_r) == WINDOW_DEPTH - 1) state_r <= S_YAW;
          cnt_r <= cnt_r + 1'b1;
        end
        S_YAW: begin
          for (int c = 0; c < 5; c++)
            avg_r[c] <= 16'((48'(acc_r[c]) * 48'(RM)) >> RK);
          state_r <= S_SIN0;
        end
        S_SIN0: begin
          if (!ref_taken_r) begin
            ref_r <= avg_r[4];
            ref_taken_r <= 1'b1;
          end
          yaw_r <= 16'(yw);
          // quadrant split
          if (yw >= 18'd27000) begin quad_r <= 2'd3; rem_r <= 14'(yw - 18'd27000); end
          else if (yw >= 18'd18000) begin quad_r <= 2'd2; rem_r <= 14'(yw - 18'd18000); end
          else if (yw >= 18'd9000) begin quad_r <= 2'd1; rem_r <= 14'(yw - 18'd9000); end
          else begin quad_r <= 2'd0; rem_r <= 14'(yw); end
          which_r <= 1'b0;
          state_r <= S_SIN1;
        end
        S_SIN1: begin
          // table lookups; integer degree and fraction via digit split
          lo_r <= sine_lut(deg);
          hi_r <= sine_lut((arg >= 14'd9000) ? 7'd90 : deg + 7'd1);
          frac_r <= (arg >= 14'd9000) ? 7'd0 : 7'(deg_frac);
          state_r <= S_SIN2;
        end
        S_SIN2: begin
          sum_r <= 38'(mul_p);
          state_r <= S_SIN3;
        end
        S_SIN3: begin
          if (which_r) begin
            sb_r <= sin_val;
            state_r <= S_SNAP;
          end else begin
            sa_r <= sin_val;
            which_r <= 1'b1;
            state_r <= S_SIN1;
          end
        end
        S_SNAP: begin
          priority if (b90) begin
            comp_r[0] <= {1'b0, avg_r[3]} + 17'd1; comp_r[1] <= {1'b0, avg_r[0]} + 17'd1;
            comp_r[2] <= {1'b0, avg_r[1]} + 17'd1; comp_r[3] <= {1'b0, avg_r[2]} + 17'd1;
            state_r <= S_OUT;
          end else if (b180) begin
            comp_r[0] <= {1'b0, avg_r[2]} + 17'd1; comp_r[1] <= {1'b0, avg_r[3]} + 17'd1;
            comp_r[2] <= {1'b0, avg_r[0]} + 17'd1; comp_r[3] <= {1'b0, avg_r[1]} + 17'd1;
            state_r <= S_OUT;
          end else if (b270) begin
            comp_r[0] <= {1'b0, avg_r[1]} + 17'd1; comp_r[1] <= {1'b0, avg_r[2]} + 17'd1;
            comp_r[2] <= {1'b0, avg_r[3]} + 17'd1; comp_r[3] <= {1'b0, avg_r[0]} + 17'd1;
            state_r <= S_OUT;
          end else begin
            dir_r <= 2'd0;
            term_r <= 1'b0;
            state_r <= S_MUL0;
          end
        end
        S_MUL0: begin
          sum_r <= 38'(mul_p);
          term_r <= 1'b1;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          sum_r <= sum_r - 38'(mul_p);
          term_r <= 1'b0;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          comp_r[dir_r] <= (rnd > 23'(CompMax)) ? CompMax : 17'(rnd);
          dir_r <= dir_r + 2'd1;
          state_r <= (dir_r == 2'd3) ? S_OUT : S_MUL0;
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_avg_north = avg_r[0];
  assign out_avg_east = avg_r[1];
  assign out_avg_south = avg_r[2];
  assign out_avg_west = avg_r[3];
  assign out_relative_yaw = yaw_r;
  assign out_comp_north = comp_r[0];
  assign out_comp_east = comp_r[1];
  assign out_comp_south = comp_r[2];
  assign out_comp_west = comp_r[3];
endmodule

/* tb/sv/tb_heading_compensated_range_filter_unit.sv */
// tb_heading_compensated_range_filter_unit: self-checking bench for the
// heading compensated range filter; depends on hcrf_pkg and the unit rtl
module tb_heading_compensated_range_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import hcrf_pkg::*;

  localparam int Depth = 8;
  localparam int CycleLimit = 600000;

  typedef struct packed {
    logic [15:0] avg_n, avg_e, avg_s, avg_w, yaw;
    logic [16:0] cmp_n, cmp_e, cmp_s, cmp_w;
  } filt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_n = '0, in_e = '0, in_s = '0, in_w = '0, in_h = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] o_an, o_ae, o_as, o_aw, o_yaw;
  logic [16:0] o_cn, o_ce, o_cs, o_cw;
  logic cfg_we = 1'b0;
  logic [9:0] cfg_tol = '0;

  heading_compensated_range_filter_unit #(.WINDOW_DEPTH(Depth)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_north_distance(in_n), .in_east_distance(in_e),
    .in_south_distance(in_s), .in_west_distance(in_w),
    .in_raw_heading(in_h),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_avg_north(o_an), .out_avg_east(o_ae), .out_avg_south(o_as),
    .out_avg_west(o_aw), .out_relative_yaw(o_yaw),
    .out_comp_north(o_cn), .out_comp_east(o_ce), .out_comp_south(o_cs),
    .out_comp_west(o_cw),
    .cfg_we(cfg_we), .cfg_snap_tolerance(cfg_tol)
  );

  always #10 clk = ~clk;

  // predictor state, mirrors the unit after reset
  logic [15:0] win_n[Depth], win_e[Depth], win_s[Depth], win_w[Depth], win_h[Depth];
  int unsigned slot_pos;
  bit ref_valid;
  logic [15:0] ref_heading;
  int unsigned tolerance;

  filt_res_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit long_hold = 1'b0;
  int unsigned stall_pct = 30;

  // first quadrant sine in q15, a in hundredths of a degree
  function automatic longint quad_sine(int unsigned a);
    int unsigned lo, hi, f;
    if (a >= QuarterTurn) return 32768;
    lo = sine_lut(7'(a / 100));
    hi = sine_lut(7'(a / 100 + 1));
    f = a % 100;
    return lo + ((hi - lo) * f + 50) / 100;
  endfunction

  function automatic logic [16:0] rotate_mag(longint own, longint nb, longint c, longint s);
    longint v;
    longint unsigned m;
    v = own * c - nb * s;
    m = (v < 0) ? -v : v;
    m = ((m + 16384) >> 15) + 1;
    return (m > 131071) ? 17'h1FFFF : 17'(m);
  endfunction

  function automatic bit near_quarter(int yaw, int centre);
    return yaw >= centre - int'(tolerance) && yaw <= centre + int'(tolerance);
  endfunction

  function automatic int unsigned window_avg(ref logic [15:0] win[Depth], input logic [15:0] v);
    int unsigned sum;
    sum = 0;
    win[slot_pos] = v;
    foreach (win[i]) sum += win[i];
    return sum / Depth;
  endfunction

  // advance the filter model by one item and queue its result
  task automatic predict_filter(logic [15:0] n, e, s, w, h);
    filt_res_t r;
    int unsigned an, ae, as_, aw, ah, q, rem;
    int d;
    longint sa, sb, sn, cs;
    an = window_avg(win_n, n);
    ae = window_avg(win_e, e);
    as_ = window_avg(win_s, s);
    aw = window_avg(win_w, w);
    ah = window_avg(win_h, h);
    slot_pos = (slot_pos + 1) % Depth;
    if (!ref_valid) begin
      ref_heading = 16'(ah);
      ref_valid = 1'b1;
    end
    d = (int'(ah) - int'(ref_heading)) % FullTurn;
    if (d < 0) d += FullTurn;
    r.avg_n = 16'(an); r.avg_e = 16'(ae); r.avg_s = 16'(as_); r.avg_w = 16'(aw);
    r.yaw = 16'(d);
    if (near_quarter(d, 9000)) begin
      r.cmp_n = 17'(aw + 1); r.cmp_e = 17'(an + 1);
      r.cmp_s = 17'(ae + 1); r.cmp_w = 17'(as_ + 1);
    end else if (near_quarter(d, 18000)) begin
      r.cmp_n = 17'(as_ + 1); r.cmp_e = 17'(aw + 1);
      r.cmp_s = 17'(an + 1); r.cmp_w = 17'(ae + 1);
    end else if (near_quarter(d, 27000)) begin
      r.cmp_n = 17'(ae + 1); r.cmp_e = 17'(as_ + 1);
      r.cmp_s = 17'(aw + 1); r.cmp_w = 17'(an + 1);
    end else begin
      q = d / QuarterTurn;
      rem = d % QuarterTurn;
      sa = quad_sine(rem);
      sb = quad_sine(QuarterTurn - rem);
      case (q)
        0: begin sn = sa; cs = sb; end
        1: begin sn = sb; cs = -sa; end
        2: begin sn = -sa; cs = -sb; end
        default: begin sn = -sb; cs = sa; end
      endcase
      r.cmp_n = rotate_mag(an, aw, cs, sn);
      r.cmp_e = rotate_mag(ae, an, cs, sn);
      r.cmp_s = rotate_mag(as_, ae, cs, sn);
      r.cmp_w = rotate_mag(aw, as_, cs, sn);
    end
    expected_q.push_back(r);
  endtask

  // offer one item, hold it until accepted, with the given gap before it;
  // valid stays up after the accept so back to back items have no gap
  task automatic send_reading(logic [15:0] n, e, s, w, h, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_n <= n; in_e <= e; in_s <= s; in_w <= w; in_h <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_filter(n, e, s, w, h);
  endtask

  int burst_left = 0;
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
  endfunction

  // drain, then allow the unit's own latency before touching the register
  task automatic write_tolerance(logic [9:0] v);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (Depth + 40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_tol <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance = v;
  endtask

  function automatic logic [15:0] rnd_dist();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 500));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_heading();
    int unsigned c;
    if ($urandom_range(0, 40) == 0) return 16'($urandom_range(36000, 65535));
    c = $urandom_range(0, 3) * 9000 + ref_heading;
    // aim for snap band edges about a quarter of the time
    if ($urandom_range(0, 3) == 0)
      return 16'((c + $urandom_range(0, 2400) - 1200) % FullTurn);
    return 16'($urandom_range(0, 35999));
  endfunction

  // result checker
  always @(posedge clk) begin
    filt_res_t got, exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      got = '{o_an, o_ae, o_as, o_aw, o_yaw, o_cn, o_ce, o_cs, o_cw};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %p got %p", exp_r, got);
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk) begin
    if (long_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("tb_heading_compensated_range_filter_unit NOT OK");
      $finish;
    end
  end

  task automatic test_directed_extremes();
    // zeros, full scale, mixed, out of range headings, heading top bit
    send_reading(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd0, 0);
    send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd35999, 0);
    send_reading(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1);
    send_reading(16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 16'd36000, 0);
    send_reading(16'hAAAA, 16'h5555, 16'h0001, 16'h8000, 16'h8000, 2);
    for (int i = 0; i < 8; i++)
      send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd35999, 0);
    // constant distances with headings cycling through the multiples of a quarter turn
    for (int i = 0; i < 8; i++)
      send_reading(16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'(9000 * (i % 4)), 0);
  endtask

  task automatic test_band_edges(logic [9:0] tol);
    logic [15:0] h;
    write_tolerance(tol);
    for (int i = 0; i < 60; i++) begin
      // constant heading over a window makes the average exact
      if (i % 8 == 0)
        h = 16'((ref_heading + $urandom_range(1, 3) * 9000 + (int'(tol) + $urandom_range(0, 2))
                 * ($urandom_range(0, 1) ? 1 : -1) + FullTurn) % FullTurn);
      send_reading(rnd_dist(), rnd_dist(), rnd_dist(), rnd_dist(), h, next_gap());
    end
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_reading(rnd_dist(), rnd_dist(), rnd_dist(), rnd_dist(), rnd_heading(), next_gap());
  endtask

  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      for (int i = 0; i < 20; i++)
        send_reading(rnd_dist(), rnd_dist(), rnd_dist(), rnd_dist(), rnd_heading(), 0);
    join
  endtask

  initial begin
    foreach (win_n[i]) begin
      win_n[i] = 0; win_e[i] = 0; win_s[i] = 0; win_w[i] = 0; win_h[i] = 0;
    end
    slot_pos = 0; ref_valid = 0; ref_heading = 0;
    tolerance = TolReset;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_band_edges(10'd0);
    test_band_edges(10'd1000);
    test_band_edges(10'd1023);
    test_band_edges(10'h2AA);
    test_band_edges(10'h155);
    stall_pct = 0;
    test_random(200);
    stall_pct = 60;
    test_backpressure();
    test_random(300);
    stall_pct = 20;
    write_tolerance(10'd500);
    test_random(400);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (Depth + 40) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("tb_heading_compensated_range_filter_unit OK");
    else
      $display("tb_heading_compensated_range_filter_unit NOT OK");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/hcrf_pkg.sv
hw/rtl/heading_compensated_range_filter_unit.sv
tb/sv/tb_heading_compensated_range_filter_unit.sv
